@@ hdl/uniform_grid_linear_resampler_macros.svh @@
// Assertion macros for the resampler
`ifndef UNIFORM_GRID_LINEAR_RESAMPLER_MACROS_SVH
`define UNIFORM_GRID_LINEAR_RESAMPLER_MACROS_SVH
// Assert that an antecedent implies a consequent in the same cycle
`define UGLR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Assert that an antecedent implies a consequent in the next cycle
`define UGLR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ hdl/uglr_pkg.sv @@
// ----------------------------------------------------------------------------
// uglr_pkg
// Types and constants shared by the resampler modules.
// ----------------------------------------------------------------------------
package uglr_pkg;
    localparam int RadW = 24;
    localparam int ValW = 32;
    localparam int IdxW = 12;
    localparam int SpcW = 16;
    localparam int NumW = 58;  // |rad diff| (24b) times |value diff| (32b), with headroom
    localparam int DenW = 25;
    localparam int QW   = 57;
    localparam logic [15:0] SpacingReset = 16'd3277;
    localparam logic        ReqAppend    = 1'b0;
    localparam logic        ReqQuery     = 1'b1;

    typedef struct packed {
        logic                   req_type;
        logic                   first_point;
        logic [RadW-1:0]        point_radius;
        logic signed [ValW-1:0] point_value;
        logic [IdxW-1:0]        sample_index;
    } in_item_t;

    typedef struct packed {
        logic [RadW-1:0]        sample_radius;
        logic signed [ValW-1:0] sample_value;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_APPEND, ST_MUL, ST_RD, ST_CMP, ST_LOAD, ST_PREP,
        ST_PROD, ST_DIV, ST_FIN, ST_OUT
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic take_item;   // register the incoming transaction
        logic do_append;   // write point and bump count if room
        logic do_mul;      // form sample radius
        logic rd_issue;    // read table entry at pointer+1
        logic step;        // advance interval pointer
        logic rd_lo;       // read entry at pointer
        logic prep;        // form differences
        logic prod;        // form product and start division
        logic div_step;    // one quotient bit
        logic finish;      // load rounded, saturated result into output
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic is_query;
        logic short_cut;   // empty, single point or index zero
        logic advance;     // search keeps going
        logic zero_den;
        logic div_done;
    } sts_t;
endpackage

@@ hdl/uniform_grid_linear_resampler.sv @@
// ----------------------------------------------------------------------------
// uniform_grid_linear_resampler
// Piecewise linear resampler of a radial point table onto a uniform grid.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready, payload in_item): an append transaction
// stores one (radius, value) point if there is room, first_point
// restarting the table; a query asks for sample index times grid_spacing.
// Output channel (out_valid/out_ready, payload out_item): one transaction
// per query, none per append.
// Sequencing: an append passes through the MUL and APPEND states. A query
// searches the intervals, each step a registered memory read (RD) and a
// compare (CMP), then loads the interval ends, forms the differences and
// the product and runs the 59-step restoring divider. An empty table, a
// single point or index zero go from RD straight to the output, a
// zero-width interval from PREP.
// One transaction is in work at a time; in_ready rises the cycle after the
// result is loaded.
// Reset clears the point count and the spacing to 0.05; the tables are
// not cleared and hold nothing meaningful until written.
// A stalled receiver holds the result in the output register; a later
// query waits in ST_OUT until that register is free.
// cfg_we/cfg_data write grid_spacing with no handshake.
// ----------------------------------------------------------------------------
module uniform_grid_linear_resampler
    import uglr_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  in_item_t        in_item,
    output logic            out_valid,
    input  logic            out_ready,
    output out_item_t       out_item,
    input  logic            cfg_we,
    input  logic [SpcW-1:0] cfg_data
);
    cmd_t            cmd;
    sts_t            sts;
    logic [SpcW-1:0] spacing_reg;

    // hold the spacing register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            spacing_reg <= SpacingReset;
        else if (cfg_we)
            spacing_reg <= cfg_data;
    end

    uglr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    uglr_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_item      (in_item),
        .grid_spacing (spacing_reg),
        .cmd          (cmd),
        .sts          (sts),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .out_item     (out_item)
    );
endmodule

@@ hdl/uglr_ctrl.sv @@
// ----------------------------------------------------------------------------
// uglr_ctrl
// Sequencer for append and query transactions.
// ----------------------------------------------------------------------------
module uglr_ctrl
    import uglr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic out_valid,
    input  logic out_ready,
    input  sts_t sts,
    output cmd_t cmd
);
    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_MUL;
            ST_MUL:    state_next = sts.is_query ? ST_RD : ST_APPEND;
            ST_APPEND: state_next = ST_IDLE;
            ST_RD:     state_next = sts.short_cut ? ST_OUT : ST_CMP;
            ST_CMP:    state_next = sts.advance ? ST_RD : ST_LOAD;
            ST_LOAD:   state_next = ST_PREP;
            ST_PREP:   state_next = sts.zero_den ? ST_OUT : ST_PROD;
            ST_PROD:   state_next = ST_DIV;
            ST_DIV:    if (sts.div_done) state_next = ST_FIN;
            ST_FIN:    state_next = ST_OUT;
            ST_OUT:    if (!out_valid || out_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:   begin in_ready = 1'b1; cmd.take_item = in_valid; end
            ST_MUL:    cmd.do_mul = 1'b1;
            ST_APPEND: cmd.do_append = 1'b1;
            ST_RD:     cmd.rd_issue = 1'b1;
            ST_CMP:    cmd.step = sts.advance;
            ST_LOAD:   cmd.rd_lo = 1'b1;
            ST_PREP:   cmd.prep = 1'b1;
            ST_PROD:   cmd.prod = 1'b1;
            ST_DIV:    cmd.div_step = 1'b1;
            ST_FIN:    ;
            ST_OUT:    cmd.finish = !out_valid || out_ready;
            default:   ;
        endcase
    end
endmodule

@@ hdl/uglr_datapath.sv @@
// ----------------------------------------------------------------------------
// uglr_datapath
// Point tables, interval search, product and restoring divider.
// ----------------------------------------------------------------------------
`include "uniform_grid_linear_resampler_macros.svh"
module uglr_datapath
    import uglr_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  in_item_t        in_item,
    input  logic [SpcW-1:0] grid_spacing,
    input  cmd_t            cmd,
    output sts_t            sts,
    input  logic            out_ready,
    output logic            out_valid,
    output out_item_t       out_item
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // result source of the current query
    localparam logic [1:0] PathInterp = 2'd0;
    localparam logic [1:0] PathLower  = 2'd1;
    localparam logic [1:0] PathFirst  = 2'd2;
    localparam logic [1:0] PathZero   = 2'd3;

    logic [RadW-1:0]        rad_mem [TABLE_DEPTH];
    logic signed [ValW-1:0] val_mem [TABLE_DEPTH];

    in_item_t               item_reg;
    logic [CW-1:0]          count_reg;
    logic [AW-1:0]          ptr_reg;
    logic [RadW-1:0]        rad_reg;
    logic [RadW-1:0]        rrd_reg;
    logic signed [ValW-1:0] vrd_reg;
    logic [RadW-1:0]        r1_reg;
    logic signed [ValW-1:0] v0_reg, v1_reg;
    logic signed [DenW-1:0] dx_reg, den_s_reg;
    logic signed [ValW:0]   dv_reg;
    logic [NumW-1:0]        rem_reg;
    logic [NumW:0]          mnum2_reg;
    logic [DenW:0]          mden2_reg;
    logic [QW-1:0]          q_reg;
    logic                   neg_reg;
    logic [5:0]             bit_reg;
    logic [1:0]             path_reg;
    logic                   out_valid_reg;
    out_item_t              out_reg;

    logic [27:0]            prod_rad;
    logic [AW-1:0]          rd_addr;
    logic                   last_iv;
    logic [CW-1:0]          wr_cnt;
    logic [RadW-1:0]        dx_mag;
    logic [ValW-1:0]        dv_mag;
    logic [DenW-1:0]        den_mag;
    logic [RadW+ValW-1:0]   mag_prod;
    logic [NumW:0]          rem_sh;

    assign prod_rad = item_reg.sample_index * grid_spacing;
    // pointer+1 during search, pointer for the lower point and the short cuts
    assign rd_addr  = (cmd.rd_lo || path_reg != PathInterp) ? ptr_reg
                                                            : AW'(ptr_reg + 1'b1);
    assign last_iv  = (CW'(ptr_reg) + CW'(2)) >= count_reg;
    assign wr_cnt   = item_reg.first_point ? '0 : count_reg;

    assign dx_mag   = RadW'(dx_reg[DenW-1] ? -dx_reg : dx_reg);
    assign dv_mag   = ValW'(dv_reg[ValW] ? -dv_reg : dv_reg);
    assign den_mag  = den_s_reg[DenW-1] ? -den_s_reg : den_s_reg;
    assign mag_prod = dx_mag * dv_mag;

    // one restoring step per cycle, bit NumW down to 0
    assign rem_sh   = {rem_reg, mnum2_reg[bit_reg]};

    always_ff @(posedge clk)
    begin
        if (cmd.take_item)
            item_reg <= in_item;
        if (cmd.do_append && wr_cnt < CW'(TABLE_DEPTH))
        begin
            rad_mem[wr_cnt[AW-1:0]] <= item_reg.point_radius;
            val_mem[wr_cnt[AW-1:0]] <= item_reg.point_value;
        end
        rrd_reg <= rad_mem[rd_addr];
        vrd_reg <= val_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cmd.do_append && wr_cnt < CW'(TABLE_DEPTH))
            count_reg <= wr_cnt + 1'b1;
        else if (cmd.do_append)
            count_reg <= wr_cnt;
    end

    // search: rd_issue reads entry ptr+1, compare in CMP
    always_ff @(posedge clk)
    begin
        if (cmd.do_mul)
        begin
            rad_reg <= (prod_rad > 28'hFFFFFF) ? '1 : prod_rad[RadW-1:0];
            ptr_reg <= '0;
            if (count_reg == '0)
                path_reg <= PathZero;
            else if (count_reg == CW'(1) || item_reg.sample_index == '0)
                path_reg <= PathFirst;
            else
                path_reg <= PathInterp;
        end
        if (cmd.step)
            ptr_reg <= ptr_reg + 1'b1;
        if (cmd.rd_lo)
            r1_reg <= rrd_reg;
        if (cmd.rd_lo)
            v1_reg <= vrd_reg;
        if (cmd.prep)
        begin
            v0_reg  <= vrd_reg;
            dx_reg  <= DenW'($signed({1'b0, rad_reg})) - DenW'($signed({1'b0, rrd_reg}));
            den_s_reg <= DenW'($signed({1'b0, r1_reg})) - DenW'($signed({1'b0, rrd_reg}));
            dv_reg  <= (ValW+1)'(v1_reg) - (ValW+1)'(vrd_reg);
            if (r1_reg == rrd_reg)
                path_reg <= PathLower;
        end
        if (cmd.prod)
        begin
            mnum2_reg <= {2'b00, mag_prod, 1'b0} + (NumW+1)'(den_mag);
            mden2_reg <= {den_mag, 1'b0};
            neg_reg   <= dx_reg[DenW-1] ^ dv_reg[ValW] ^ den_s_reg[DenW-1];
            rem_reg   <= '0;
            q_reg     <= '0;
            bit_reg   <= 6'(NumW);
        end
        if (cmd.div_step)
        begin
            if (rem_sh >= (NumW+1)'(mden2_reg))
            begin
                rem_reg <= NumW'(rem_sh - (NumW+1)'(mden2_reg));
                q_reg   <= {q_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= NumW'(rem_sh);
                q_reg   <= {q_reg[QW-2:0], 1'b0};
            end
            bit_reg <= bit_reg - 1'b1;
        end
    end

    // quotient fits: q <= |num| + 1 < 2^57, so QW bits hold it exactly
    logic signed [ValW+QW:0] sum;
    logic [QW-1:0]           q_use;
    logic signed [ValW-1:0]  res;
    assign q_use = q_reg;
    assign sum = neg_reg ? (ValW+QW+1)'(v0_reg) - (ValW+QW+1)'($signed({1'b0, q_use}))
                         : (ValW+QW+1)'(v0_reg) + (ValW+QW+1)'($signed({1'b0, q_use}));
    always_comb
    begin
        unique case (path_reg)
            PathZero:  res = '0;
            PathFirst: res = vrd_reg;
            PathLower: res = v0_reg;
            default:
                if (sum > (ValW+QW+1)'(32'sh7FFFFFFF))
                    res = 32'sh7FFFFFFF;
                else if (sum < -(ValW+QW+1)'(33'sh80000000))
                    res = 32'sh80000000;
                else
                    res = sum[ValW-1:0];
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_reg.sample_radius <= rad_reg;
            out_reg.sample_value  <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.finish)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign sts.is_query  = item_reg.req_type == ReqQuery;
    assign sts.short_cut = path_reg != PathInterp;
    assign sts.advance   = !last_iv && (rrd_reg < rad_reg);
    assign sts.zero_den  = r1_reg == rrd_reg;
    assign sts.div_done  = bit_reg == '0;
    assign out_valid     = out_valid_reg;
    assign out_item      = out_reg;

    `UGLR_ASSERT_IMP(a_cnt_max, clk, rst_n, 1'b1, count_reg <= CW'(TABLE_DEPTH),
        "point count beyond table depth")
    `UGLR_ASSERT_NEXT(a_fin_valid, clk, rst_n, cmd.finish, out_valid_reg,
        "result not presented after finish")
    `UGLR_ASSERT_IMP(a_ptr_range, clk, rst_n, cmd.step, CW'(ptr_reg) + CW'(2) < count_reg,
        "search pointer past last interval")
endmodule
